/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the block bitmap allocator
// Request and result items, action codes, sequencer states and the word
// count helper used by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int WORD_BITS       = 8;
    localparam int MAX_BLOCKS_DEF  = 1024;
    localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;

    typedef enum logic [2:0] {
        ACT_FIRST_FREE = 3'd0,
        ACT_FIRST_FIT  = 3'd1,
        ACT_MARK_USED  = 3'd2,
        ACT_MARK_FREE  = 3'd3,
        ACT_QUERY      = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [9:0]  start_block;
        logic [10:0] run_length;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [9:0]  block_index;
        logic [10:0] free_count;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic init;
        logic step;
    } t_scan_ctl;

    // Number of map words covered by a block count, capped at the map depth.
    function automatic int active_words(logic [10:0] count, int depth);
        int w;
        w = int'(count[10:3]);
        if (w > depth) begin
            w = depth;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram: generic single write port RAM with registered read
// One write and one read per cycle at independent addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/bba_scan.sv */
// ----------------------------------------------------------------------------
// bba_scan: shared word unit of the block bitmap allocator
// Applies a range mark to one map word, tracks the first-fit run across
// words and accumulates the free block count of the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_scan #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    localparam int DEPTH = MAX_BLOCKS / bba_pkg::WORD_BITS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int PW    = AW + 3,
    localparam int CW    = $clog2(MAX_BLOCKS + 1),
    localparam int RW    = (CW > 11) ? CW : 11,
    localparam int EW    = ((PW > 10) ? PW : 10) + 2,
    localparam int PCW   = $clog2(bba_pkg::WORD_BITS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bba_pkg::t_scan_ctl                i_ctl,
    input  wire bba_pkg::t_in_item                 i_req,
    input  wire logic [bba_pkg::WORD_BITS-1:0]     i_word,
    input  wire logic [PW-1:0]                     i_base,
    output logic      [bba_pkg::WORD_BITS-1:0]     o_word,
    output logic                                   o_found,
    output logic      [PW-1:0]                     o_pos,
    output logic      [CW-1:0]                     o_free
);

    import bba_pkg::*;

    logic            r_found;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   r_start;
    logic [RW-1:0]   r_run;
    logic [CW-1:0]   r_free;

    logic            is_mark;
    logic            is_search;
    logic            mark_val;
    logic [RW-1:0]   len_eff;
    logic [EW-1:0]   range_lo;
    logic [EW-1:0]   range_hi;

    logic [PW-1:0]   c_blk [WORD_BITS];
    logic [WORD_BITS-1:0] c_word;
    logic            c_found;
    logic [PW-1:0]   c_pos;
    logic [PW-1:0]   c_start;
    logic [RW-1:0]   c_run;
    logic [PCW-1:0]  c_pc;

    assign is_mark   = i_req.action inside {ACT_MARK_USED, ACT_MARK_FREE};
    assign is_search = i_req.action inside {ACT_FIRST_FREE, ACT_FIRST_FIT};
    assign mark_val  = (i_req.action == ACT_MARK_USED);
    assign len_eff   = (i_req.action == ACT_FIRST_FREE || i_req.run_length == '0)
                       ? RW'(1) : RW'(i_req.run_length);
    assign range_lo  = EW'(i_req.start_block);
    assign range_hi  = EW'(i_req.start_block) + EW'(i_req.run_length);

    always_comb begin
        c_found = r_found;
        c_pos   = r_pos;
        c_start = r_start;
        c_run   = r_run;
        c_pc    = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            c_blk[j] = i_base | PW'(j);
            if (is_mark && EW'(c_blk[j]) >= range_lo && EW'(c_blk[j]) < range_hi) begin
                c_word[j] = mark_val;
            end else begin
                c_word[j] = i_word[j];
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            if (c_word[j]) begin
                c_run   = '0;
                c_start = PW'(c_blk[j] + 1'b1);
            end else begin
                c_run = c_run + RW'(1);
                if (!c_found && is_search && c_run >= len_eff) begin
                    c_found = 1'b1;
                    c_pos   = c_start;
                end
            end
            c_pc = c_pc + PCW'(!c_word[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_found <= 1'b0;
            r_pos   <= '0;
            r_start <= '0;
            r_run   <= '0;
            r_free  <= '0;
        end else if (i_ctl.step) begin
            r_found <= c_found;
            r_pos   <= c_pos;
            r_start <= c_start;
            r_run   <= c_run;
            r_free  <= r_free + CW'(c_pc);
        end
    end

    assign o_word  = c_word;
    assign o_found = r_found;
    assign o_pos   = r_pos;
    assign o_free  = r_free;

endmodule

`default_nettype wire

/* rtl/block_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// block_bitmap_allocator: first-fit bitmap block allocator
// Each request scans the active map words in order from word 0; one map word
// of eight blocks passes the unit a cycle.
// A new request is taken only once the result of the last one is registered.
// Reset: a clearing pass zeroes all MAX_BLOCKS/8 map words, requests are
// stalled meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    localparam int DEPTH = MAX_BLOCKS / bba_pkg::WORD_BITS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW    = $clog2(DEPTH + 1),
    localparam int PW    = AW + 3,
    localparam int CW    = $clog2(MAX_BLOCKS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bba_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bba_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [10:0]        i_cfg_wdata
);

    import bba_pkg::*;

    t_state      r_state, n_state;
    logic [NW-1:0] r_addr, n_addr;
    logic        r_pv, n_pv;
    logic [AW-1:0] r_paddr, n_paddr;
    t_in_item    r_req, n_req;
    logic [NW-1:0] r_num_words, n_num_words;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    t_scan_ctl   scan_ctl;
    logic [WORD_BITS-1:0] scan_word;
    logic        scan_found;
    logic [PW-1:0] scan_pos;
    logic [CW-1:0] scan_free;

    logic        req_mark;
    logic        req_search;
    logic        out_free;

    assign req_mark   = r_req.action inside {ACT_MARK_USED, ACT_MARK_FREE};
    assign req_search = r_req.action inside {ACT_FIRST_FREE, ACT_FIRST_FIT};
    assign out_free   = !r_out_valid || !i_out_stall;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    bba_scan #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_req   (r_req),
        .i_word  (ram_rdata),
        .i_base  ({r_paddr, 3'b000}),
        .o_word  (scan_word),
        .o_found (scan_found),
        .o_pos   (scan_pos),
        .o_free  (scan_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_num_words <= NW'(active_words(BLOCK_COUNT_RST, DEPTH));
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            r_num_words <= n_num_words;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= n_paddr;
        r_req   <= n_req;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pv        = 1'b0;
        n_paddr     = r_paddr;
        n_req       = r_req;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_num_words = i_cfg_we ? NW'(active_words(i_cfg_wdata, DEPTH)) : r_num_words;
        ram_we      = 1'b0;
        ram_waddr   = r_paddr;
        ram_wdata   = scan_word;
        scan_ctl    = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[AW-1:0];
                ram_wdata = '0;
                n_addr    = r_addr + NW'(1);
                if (r_addr == NW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req         = i_in_item;
                    n_addr        = '0;
                    scan_ctl.init = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_ctl.step = r_pv;
                ram_we        = r_pv && req_mark;
                if (r_addr < r_num_words) begin
                    n_addr  = r_addr + NW'(1);
                    n_pv    = 1'b1;
                    n_paddr = r_addr[AW-1:0];
                end else if (!r_pv && out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.free_count  = 11'(scan_free);
                    if (req_search) begin
                        n_out.found       = scan_found;
                        n_out.block_index = scan_found ? 10'(scan_pos) : '0;
                    end else if (req_mark) begin
                        n_out.found       = 1'b1;
                        n_out.block_index = r_req.start_block;
                    end else begin
                        n_out.found       = 1'b1;
                        n_out.block_index = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_write_only_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && ram_we) |->
            (r_req.action == ACT_MARK_USED || r_req.action == ACT_MARK_FREE))
        else $error("map written during a request that does not mark");

    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pv)
        else $error("word still in flight while idle");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_SCAN))
        else $error("result raised outside a scan");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.block_index == '0))
        else $error("failed search reports a nonzero block");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_num_words))
        else $error("scan address passed the active word count");
`endif

endmodule

`default_nettype wire
